>>> design/dtd_pkg.sv
package dtd_pkg;

    // field widths
    localparam int SAMPLE_BITS   = 12;
    localparam int TIME_BITS     = 32;
    localparam int CFG_DATA_BITS = (TIME_BITS > SAMPLE_BITS) ? TIME_BITS : SAMPLE_BITS;
    localparam int CFG_INDEX_BITS = 1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_THRESHOLD_CODE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT_MS     = 1'd1;

    // configuration reset values
    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(1218);
    localparam logic [TIME_BITS-1:0]   TIMEOUT_RESET   = TIME_BITS'(20000);

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_START  = 2'd1,
        CMD_STREAM = 2'd2,
        CMD_STOP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACK_NONE    = 2'd0,
        ACK_MEASURE = 2'd1,
        ACK_STREAM  = 2'd2,
        ACK_STOPPED = 2'd3
    } ack_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_ARRIVED = 2'd1,
        EV_GONE    = 2'd2,
        EV_TIMEOUT = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_MEASURE = 2'd1,
        MODE_STREAM  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        LED_OFF   = 2'd0,
        LED_RED   = 2'd1,
        LED_GREEN = 2'd2
    } led_t;

    typedef struct packed {
        logic [1:0]             command;
        logic [SAMPLE_BITS-1:0] sample;
        logic [TIME_BITS-1:0]   now_ms;
    } item_t;

    typedef struct packed {
        logic                   laser_on;
        logic [1:0]             led_color;
        logic [1:0]             command_ack;
        logic [1:0]             signal_event;
        logic                   stream_valid;
        logic [SAMPLE_BITS-1:0] stream_sample;
    } result_t;

    // detector state carried between items
    typedef struct packed {
        mode_t                mode;
        logic                 below_flag;
        logic [TIME_BITS-1:0] start_time;
        led_t                 led;
    } dtd_state_t;

endpackage

>>> design/dtd_core.sv
module dtd_core
(
    input  dtd_pkg::item_t              item,
    input  dtd_pkg::dtd_state_t         state,
    input  logic [dtd_pkg::SAMPLE_BITS-1:0] threshold_code,
    input  logic [dtd_pkg::TIME_BITS-1:0]   timeout_ms,
    output dtd_pkg::dtd_state_t         state_next,
    output dtd_pkg::result_t            result
);

    dtd_pkg::dtd_state_t          st;
    dtd_pkg::ack_t                ack;
    dtd_pkg::event_t              ev;
    logic                         echo;
    logic                         below;
    logic [dtd_pkg::TIME_BITS-1:0] elapsed;

    assign below = item.sample < threshold_code;

    always_comb
    begin
        st      = state;
        ack     = dtd_pkg::ACK_NONE;
        ev      = dtd_pkg::EV_NONE;
        echo    = 1'b0;
        elapsed = '0;

        // command first
        case (dtd_pkg::cmd_t'(item.command))
            dtd_pkg::CMD_START:
            begin
                if (st.mode != dtd_pkg::MODE_MEASURE)
                begin
                    st.start_time = item.now_ms;
                    st.mode       = dtd_pkg::MODE_MEASURE;
                    st.below_flag = 1'b0;
                    st.led        = dtd_pkg::LED_RED;
                    ack           = dtd_pkg::ACK_MEASURE;
                end
            end
            dtd_pkg::CMD_STREAM:
            begin
                if (st.mode != dtd_pkg::MODE_STREAM)
                begin
                    st.mode = dtd_pkg::MODE_STREAM;
                    st.led  = dtd_pkg::LED_RED;
                    ack     = dtd_pkg::ACK_STREAM;
                end
            end
            dtd_pkg::CMD_STOP:
            begin
                st.mode = dtd_pkg::MODE_IDLE;
                st.led  = dtd_pkg::LED_OFF;
                ack     = dtd_pkg::ACK_STOPPED;
            end
            default:
            begin
            end
        endcase

        // then the sample, in the resulting mode
        elapsed = item.now_ms - st.start_time;
        if (st.mode == dtd_pkg::MODE_MEASURE && elapsed > timeout_ms)
        begin
            st.mode = dtd_pkg::MODE_IDLE;
            st.led  = dtd_pkg::LED_OFF;
            ev      = dtd_pkg::EV_TIMEOUT;
        end
        else if (st.mode == dtd_pkg::MODE_MEASURE || st.mode == dtd_pkg::MODE_STREAM)
        begin
            echo = (st.mode == dtd_pkg::MODE_STREAM);
            if (!st.below_flag && below)
            begin
                st.below_flag = 1'b1;
                st.led        = dtd_pkg::LED_GREEN;
                ev            = dtd_pkg::EV_ARRIVED;
            end
            else if (st.below_flag && !below)
            begin
                st.below_flag = 1'b0;
                st.led        = dtd_pkg::LED_RED;
                ev            = dtd_pkg::EV_GONE;
            end
        end
    end

    assign state_next = st;

    assign result.laser_on      = (st.mode == dtd_pkg::MODE_MEASURE)
                                  || (st.mode == dtd_pkg::MODE_STREAM);
    assign result.led_color     = st.led;
    assign result.command_ack   = ack;
    assign result.signal_event  = ev;
    assign result.stream_valid  = echo;
    assign result.stream_sample = echo ? item.sample : '0;

endmodule

>>> design/droplet_threshold_detector_unit.sv
// channel   | handshake                  | payload
// ----------+----------------------------+--------------------------------
// item      | item_valid / item_ready    | item_data (command, sample, time)
// result    | result_valid / result_ready| result_data (laser, led, ack, event, echo)
// config    | cfg_write                  | cfg_index, cfg_data
//
// one transaction per cycle sustained while result_ready holds; an item reaches the result
// through the input register, then decision logic into the result register
// the detector state register is updated in the same cycle as the result register
// asynchronous active-low reset: mode idle, flag clear, led off, config to defaults
// a stalled result holds the pipe; the input register still takes an item while empty
module droplet_threshold_detector_unit
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               item_valid,
    output logic                               item_ready,
    input  dtd_pkg::item_t                     item_data,

    output logic                               result_valid,
    input  logic                               result_ready,
    output dtd_pkg::result_t                   result_data,

    input  logic                               cfg_write,
    input  logic [dtd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dtd_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    // configuration registers
    logic [dtd_pkg::SAMPLE_BITS-1:0] threshold_reg;
    logic [dtd_pkg::TIME_BITS-1:0]   timeout_reg;

    // input stage
    logic                            in_valid_reg;
    dtd_pkg::item_t                  in_data_reg;

    // detector state and result stage
    dtd_pkg::dtd_state_t             state_reg;
    dtd_pkg::dtd_state_t             state_next;
    dtd_pkg::result_t                result_next;
    logic                            out_valid_reg;
    dtd_pkg::result_t                out_data_reg;

    logic                            advance;

    // the input stage moves on when the result register is free or being emptied
    assign advance    = !out_valid_reg || result_ready;
    assign item_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= dtd_pkg::THRESHOLD_RESET;
            timeout_reg   <= dtd_pkg::TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                dtd_pkg::CFG_THRESHOLD_CODE: threshold_reg <= cfg_data[dtd_pkg::SAMPLE_BITS-1:0];
                dtd_pkg::CFG_TIMEOUT_MS:     timeout_reg   <= cfg_data[dtd_pkg::TIME_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            in_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            in_data_reg <= item_data;
        end
    end

    // command and sample decision
    dtd_core u_core
    (
        .item           (in_data_reg),
        .state          (state_reg),
        .threshold_code (threshold_reg),
        .timeout_ms     (timeout_reg),
        .state_next     (state_next),
        .result         (result_next)
    );

    // state and result commit together when an item leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode       <= dtd_pkg::MODE_IDLE;
            state_reg.below_flag <= 1'b0;
            state_reg.start_time <= '0;
            state_reg.led        <= dtd_pkg::LED_OFF;
            out_valid_reg        <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            out_data_reg <= result_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    // the held result always reflects the current mode
    a_laser_matches_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.laser_on == (state_reg.mode != dtd_pkg::MODE_IDLE)))
        else $error("laser_on disagrees with mode");

    // a timeout leaves the laser and led off
    a_timeout_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.signal_event == dtd_pkg::EV_TIMEOUT)
        |-> (!out_data_reg.laser_on && out_data_reg.led_color == dtd_pkg::LED_OFF))
        else $error("timeout without going idle");

    // echo only while the laser is on
    a_echo_active: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.stream_valid) |-> out_data_reg.laser_on)
        else $error("stream echo while idle");

    // a stalled result freezes the detector state
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ready) |=> $stable(state_reg))
        else $error("state changed during a stall");

endmodule
